// ===== rtl/bup_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup_pkg
// Shared types, codes and constants of the power-of-two bilinear upscaler.
// ----------------------------------------------------------------------------
package bup_pkg;

  // default source image bounds
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // exponent saturation limit and derived widths
  localparam logic [2:0] SHIFT_LIMIT = 3'd4;
  localparam int DIM_W  = 11;  // holds a coordinate plus carry, or size << shift
  localparam int IDX_W  = 8;   // neighbour index before edge handling
  localparam int WGT_W  = 5;   // one axis weight, 0..16
  localparam int PROD_W = 9;   // product of two axis weights, up to 256
  localparam int ACC_W  = 16;  // weighted channel sum
  localparam int TOT_W  = 4;   // x_shift + y_shift

  // register reset values
  localparam logic [6:0] RST_SRC_WIDTH  = 7'd64;
  localparam logic [6:0] RST_SRC_HEIGHT = 7'd64;

  // item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_X_SHIFT    = 3'd2;
  localparam logic [2:0] CFG_Y_SHIFT    = 3'd3;
  localparam logic [2:0] CFG_EDGE_MODE  = 3'd4;

  // neighbour fetch order
  localparam logic [1:0] NB_TL = 2'd0;
  localparam logic [1:0] NB_TR = 2'd1;
  localparam logic [1:0] NB_BL = 2'd2;
  localparam logic [1:0] NB_BR = 2'd3;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_FETCH,
    S_LAST,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       wr;
    logic       load_q;
    logic       calc;
    logic       rd_en;
    logic [1:0] rd_sel;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic q_err;
  } dp_status_t;

endpackage

// ===== rtl/bup_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bup_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bup_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup_ctrl
// Sequencer: accepts items, steps an in-range query through setup, four
// neighbour fetches, the final accumulate and the result strobe.
// ----------------------------------------------------------------------------
module bup_ctrl
  import bup_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_opcode,
  input  dp_status_t status,
  output logic       busy,
  output logic       out_valid,
  output ctrl_cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;

  assign accept = start && !busy;

  // state and fetch counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r) inside
      S_IDLE, S_DONE: begin
        if (accept && in_opcode == OP_QUERY) begin
          state_nxt = S_SETUP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SETUP: begin
        cnt_nxt   = '0;
        state_nxt = status.q_err ? S_DONE : S_FETCH;
      end
      S_FETCH: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == NB_BR) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_DONE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy       = 1'b1;
    out_valid  = 1'b0;
    cmd        = '0;
    cmd.rd_sel = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
      end
      S_DONE: begin
        busy      = 1'b0;
        out_valid = 1'b1;
      end
      S_SETUP: begin
        cmd.calc = 1'b1;
      end
      S_FETCH: begin
        cmd.rd_en = 1'b1;
      end
      S_LAST: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
    cmd.wr     = accept && in_opcode == OP_WRITE;
    cmd.load_q = accept && in_opcode == OP_QUERY;
  end

  // accepted query always enters setup
  a_query_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_QUERY) |=> state_r == S_SETUP)
    else $error("query not followed by setup");

  // fourth fetch leads to the final accumulate
  a_fetch_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH && cnt_r == NB_BR) |=> state_r == S_LAST)
    else $error("fetch sequence overran");

  // result strobe only after an accumulate or a range error
  a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> ($past(state_r) == S_LAST || $past(state_r) == S_SETUP))
    else $error("result strobe without a finished query");

endmodule

// ===== rtl/bup_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bup_dp
// Datapath: configuration registers, source image RAM, neighbour and weight
// setup, and the per-channel multiply-accumulate.
// ----------------------------------------------------------------------------
module bup_dp
  import bup_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic [9:0] in_coord_x,
  input  logic [9:0] in_coord_y,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic [7:0] out_frac_red,
  output logic [7:0] out_frac_green,
  output logic [7:0] out_frac_blue,
  output logic [7:0] out_frac_alpha,
  output logic       out_range_error
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XIW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YIW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // configuration registers
  logic [6:0] src_width_r, src_height_r;
  logic [2:0] x_shift_r, y_shift_r;
  logic       edge_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RST_SRC_WIDTH;
      src_height_r <= RST_SRC_HEIGHT;
      x_shift_r    <= '0;
      y_shift_r    <= '0;
      edge_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data;
        CFG_SRC_HEIGHT: src_height_r <= cfg_data;
        CFG_X_SHIFT:    x_shift_r    <= cfg_data[2:0];
        CFG_Y_SHIFT:    y_shift_r    <= cfg_data[2:0];
        CFG_EDGE_MODE:  edge_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective sizes and exponents
  logic [6:0] eff_w, eff_h;
  logic [2:0] eff_xs, eff_ys;

  always_comb begin
    if (src_width_r == '0) begin
      eff_w = 7'd1;
    end else if ({4'b0, src_width_r} > DIM_W'(MAX_WIDTH)) begin
      eff_w = 7'(MAX_WIDTH);
    end else begin
      eff_w = src_width_r;
    end
    if (src_height_r == '0) begin
      eff_h = 7'd1;
    end else if ({4'b0, src_height_r} > DIM_W'(MAX_HEIGHT)) begin
      eff_h = 7'(MAX_HEIGHT);
    end else begin
      eff_h = src_height_r;
    end
    eff_xs = (x_shift_r > SHIFT_LIMIT) ? SHIFT_LIMIT : x_shift_r;
    eff_ys = (y_shift_r > SHIFT_LIMIT) ? SHIFT_LIMIT : y_shift_r;
  end

  // source pixel write
  logic          wr_ok;
  logic [AW-1:0] waddr;

  assign wr_ok = ({1'b0, in_coord_x} < {4'b0, eff_w}) && ({1'b0, in_coord_y} < {4'b0, eff_h});
  assign waddr = AW'(AW'(XIW'(in_coord_x)) + AW'(AW'(YIW'(in_coord_y)) * AW'(MAX_WIDTH)));

  // query coordinates
  logic [9:0] q_x_r, q_y_r;

  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      q_x_r <= in_coord_x;
      q_y_r <= in_coord_y;
    end
  end

  // range check, neighbour indexes and weights
  logic [DIM_W-1:0] lim_x, lim_y, xp, yp;
  logic [WGT_W-1:0] sx, sy, hxw, lxw, hyw, lyw;
  logic [IDX_W-1:0] hxi, hyi, lx_i, hx_i, ly_i, hy_i;
  logic             q_err;

  always_comb begin
    lim_x = DIM_W'({4'b0, eff_w} << eff_xs);
    lim_y = DIM_W'({4'b0, eff_h} << eff_ys);
    q_err = ({1'b0, q_x_r} >= lim_x) || ({1'b0, q_y_r} >= lim_y);
    sx    = WGT_W'(5'd1 << eff_xs);
    sy    = WGT_W'(5'd1 << eff_ys);
    xp    = {1'b0, q_x_r} + DIM_W'(sx >> 1);
    yp    = {1'b0, q_y_r} + DIM_W'(sy >> 1);
    hxi   = IDX_W'(xp >> eff_xs);
    hyi   = IDX_W'(yp >> eff_ys);
    hxw   = WGT_W'(xp) & (sx - 5'd1);
    hyw   = WGT_W'(yp) & (sy - 5'd1);
    lxw   = sx - hxw;
    lyw   = sy - hyw;
    // low neighbour: index -1 clamps or wraps
    if (hxi == '0) begin
      lx_i = edge_mode_r ? IDX_W'(eff_w - 7'd1) : '0;
    end else begin
      lx_i = hxi - 8'd1;
    end
    if (hyi == '0) begin
      ly_i = edge_mode_r ? IDX_W'(eff_h - 7'd1) : '0;
    end else begin
      ly_i = hyi - 8'd1;
    end
    // high neighbour: index equal to the size clamps or wraps
    if (hxi >= {1'b0, eff_w}) begin
      hx_i = edge_mode_r ? '0 : IDX_W'(eff_w - 7'd1);
    end else begin
      hx_i = hxi;
    end
    if (hyi >= {1'b0, eff_h}) begin
      hy_i = edge_mode_r ? '0 : IDX_W'(eff_h - 7'd1);
    end else begin
      hy_i = hyi;
    end
  end

  assign status.q_err = q_err;

  // registered setup results
  logic [XIW-1:0]    lx_r, hx_r;
  logic [YIW-1:0]    ly_r, hy_r;
  logic [PROD_W-1:0] w_tl_r, w_tr_r, w_bl_r, w_br_r;
  logic [TOT_W-1:0]  tot_r;
  logic              err_r;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      lx_r   <= XIW'(lx_i);
      hx_r   <= XIW'(hx_i);
      ly_r   <= YIW'(ly_i);
      hy_r   <= YIW'(hy_i);
      w_tl_r <= PROD_W'({4'b0, lxw} * {4'b0, lyw});
      w_tr_r <= PROD_W'({4'b0, hxw} * {4'b0, lyw});
      w_bl_r <= PROD_W'({4'b0, lxw} * {4'b0, hyw});
      w_br_r <= PROD_W'({4'b0, hxw} * {4'b0, hyw});
      tot_r  <= TOT_W'({1'b0, eff_xs} + {1'b0, eff_ys});
      err_r  <= q_err;
    end
  end

  // neighbour read address
  logic [XIW-1:0] rx;
  logic [YIW-1:0] ry;
  logic [AW-1:0]  raddr;

  always_comb begin
    case (cmd.rd_sel)
      NB_TL:   begin rx = lx_r; ry = ly_r; end
      NB_TR:   begin rx = hx_r; ry = ly_r; end
      NB_BL:   begin rx = lx_r; ry = hy_r; end
      default: begin rx = hx_r; ry = hy_r; end
    endcase
  end

  assign raddr = AW'(AW'(rx) + AW'(AW'(ry) * AW'(MAX_WIDTH)));

  // source image store
  logic [31:0] rdata;

  bup_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr && wr_ok),
    .waddr (waddr),
    .wdata ({in_alpha, in_blue, in_green, in_red}),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // read data arrives in the cycle after the address
  logic       acc_en_r;
  logic [1:0] acc_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    acc_sel_r <= cmd.rd_sel;
  end

  // weight of the pixel being accumulated
  logic [PROD_W-1:0] wsel;

  always_comb begin
    case (acc_sel_r)
      NB_TL:   wsel = w_tl_r;
      NB_TR:   wsel = w_tr_r;
      NB_BL:   wsel = w_bl_r;
      default: wsel = w_br_r;
    endcase
  end

  // per-channel multiply-accumulate
  logic [ACC_W-1:0] acc_r [4];
  logic [ACC_W-1:0] frac_mask;
  logic [7:0]       quot [4];
  logic [7:0]       frac [4];

  for (genvar c = 0; c < 4; c++) begin : g_chan
    logic [16:0] prod;

    assign prod = 17'(rdata[8*c +: 8]) * 17'(wsel);

    always_ff @(posedge clk) begin
      if (cmd.calc) begin
        acc_r[c] <= '0;
      end else if (acc_en_r) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod);
      end
    end

    assign quot[c] = 8'(acc_r[c] >> tot_r);
    assign frac[c] = 8'(acc_r[c] & frac_mask);
  end

  assign frac_mask = (ACC_W'(1) << tot_r) - ACC_W'(1);

  // result fields
  assign out_red         = quot[0];
  assign out_green       = quot[1];
  assign out_blue        = quot[2];
  assign out_alpha       = quot[3];
  assign out_frac_red    = frac[0];
  assign out_frac_green  = frac[1];
  assign out_frac_blue   = frac[2];
  assign out_frac_alpha  = frac[3];
  assign out_range_error = err_r;

endmodule

// ===== rtl/bilinear_upscale_pow2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_upscale_pow2
// Power-of-two bilinear upscaler over a stored RGBA source image.
// ----------------------------------------------------------------------------
// Usage:
//   Input items are taken when start is high and busy is low. in_opcode
//   selects a source pixel write (coordinates in the source image) or a
//   query (coordinates in the image enlarged by 2^x_shift by 2^y_shift).
//   A write finishes in the cycle it is taken and gives no result; writes
//   outside the source image are dropped.
//   A query gives one result, shown for exactly one cycle with out_valid.
//   The receiver cannot stall; the result must be taken in that cycle.
//   A query in range passes through a setup step, four reads of the single
//   read port of the image RAM and an accumulate step before out_valid; a
//   query outside the enlarged image returns zeros with out_range_error
//   straight from the setup step. busy stays high until the result is shown.
//   busy is low while the result is shown, so the next item may be taken
//   in the strobe cycle.
//   The user must write configuration registers through cfg_we/cfg_index/
//   cfg_data only while idle; the block does not enforce it. Reset restores
//   register defaults and the sequencer; image RAM is undefined until written.
// ----------------------------------------------------------------------------
module bilinear_upscale_pow2
  import bup_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  // input items
  input  logic       start,
  output logic       busy,
  input  logic       in_opcode,
  input  logic [9:0] in_coord_x,
  input  logic [9:0] in_coord_y,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  // results
  output logic       out_valid,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic [7:0] out_frac_red,
  output logic [7:0] out_frac_green,
  output logic [7:0] out_frac_blue,
  output logic [7:0] out_frac_alpha,
  output logic       out_range_error,
  // configuration
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [6:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  bup_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .status    (status),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // datapath
  bup_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_frac_red    (out_frac_red),
    .out_frac_green  (out_frac_green),
    .out_frac_blue   (out_frac_blue),
    .out_frac_alpha  (out_frac_alpha),
    .out_range_error (out_range_error)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the power-of-two bilinear upscaler.
// Loads the source image over the item port and fires queries across several
// register settings. These include zero and oversized sizes, saturating
// shifts and both edge modes. Every query result is compared field by field
// against an in-bench interpolator that keeps its own copy of the image and
// the registers.
// ----------------------------------------------------------------------------

package tb_upscale_pkg;
  import bup_pkg::*;

  localparam int MAX_PIXELS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  // one input item as seen at the ports
  typedef struct packed {
    logic       opcode;
    logic [9:0] coord_x;
    logic [9:0] coord_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_item_t;

  // one query result
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] frac_red;
    logic [7:0] frac_green;
    logic [7:0] frac_blue;
    logic [7:0] frac_alpha;
    logic       range_error;
  } pixel_result_t;

  class upscale_scoreboard;
    logic [31:0]   shadow_image [MAX_PIXELS];
    bit            loaded [MAX_PIXELS];
    logic [6:0]    width_reg;
    logic [6:0]    height_reg;
    logic [2:0]    xshift_reg;
    logic [2:0]    yshift_reg;
    logic          wrap_reg;
    pixel_result_t expected_pixels [$];
    int unsigned   errors;
    int unsigned   writes_taken;
    int unsigned   queries_taken;
    int unsigned   outside_queries;
    int unsigned   results_checked;

    function new();
      width_reg  = RST_SRC_WIDTH;
      height_reg = RST_SRC_HEIGHT;
      xshift_reg = '0;
      yshift_reg = '0;
      wrap_reg   = 1'b0;
      foreach (loaded[i]) loaded[i] = 1'b0;
      foreach (shadow_image[i]) shadow_image[i] = '0;
    endfunction

    // register writes as the block sees them
    function void set_register(logic [2:0] index, logic [6:0] value);
      case (index)
        CFG_SRC_WIDTH:  width_reg  = value;
        CFG_SRC_HEIGHT: height_reg = value;
        CFG_X_SHIFT:    xshift_reg = value[2:0];
        CFG_Y_SHIFT:    yshift_reg = value[2:0];
        CFG_EDGE_MODE:  wrap_reg   = value[0];
        default: ;
      endcase
    endfunction

    // zero size acts as one, oversized saturates
    function int eff_width();
      if (width_reg == 0) return 1;
      return (int'(width_reg) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
    endfunction

    function int eff_height();
      if (height_reg == 0) return 1;
      return (int'(height_reg) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
    endfunction

    function int eff_xshift();
      return (xshift_reg > SHIFT_LIMIT) ? int'(SHIFT_LIMIT) : int'(xshift_reg);
    endfunction

    function int eff_yshift();
      return (yshift_reg > SHIFT_LIMIT) ? int'(SHIFT_LIMIT) : int'(yshift_reg);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // neighbour index from -1 .. size into the image
    function int wrap_or_clamp(int idx, int size);
      if (idx < 0) return wrap_reg ? size - 1 : 0;
      if (idx >= size) return wrap_reg ? idx - size : size - 1;
      return idx;
    endfunction

    // bilinear blend of the four neighbours of one enlarged pixel
    function pixel_result_t interpolate_pixel(logic [9:0] cx, logic [9:0] cy);
      pixel_result_t res;
      logic [31:0]   nb [4];
      int            wgt [4];
      logic [7:0]    quo [4];
      logic [7:0]    rem [4];
      int w, h, xs, ys, xp, yp, hxi, hyi, hxw, hyw, lxw, lyw;
      int lx, hx, ly, hy, tot, sum;
      res = '0;
      w  = eff_width();
      h  = eff_height();
      xs = eff_xshift();
      ys = eff_yshift();
      if (int'(cx) >= (w << xs) || int'(cy) >= (h << ys)) begin
        res.range_error = 1'b1;
        return res;
      end
      // half-scale offset, high neighbour and its weight per axis
      xp  = int'(cx) + ((1 << xs) >> 1);
      yp  = int'(cy) + ((1 << ys) >> 1);
      hxi = xp >> xs;
      hyi = yp >> ys;
      hxw = xp & ((1 << xs) - 1);
      hyw = yp & ((1 << ys) - 1);
      lxw = (1 << xs) - hxw;
      lyw = (1 << ys) - hyw;
      lx  = wrap_or_clamp(hxi - 1, w);
      hx  = wrap_or_clamp(hxi, w);
      ly  = wrap_or_clamp(hyi - 1, h);
      hy  = wrap_or_clamp(hyi, h);
      nb[0]  = shadow_image[ly * DEF_MAX_WIDTH + lx];
      nb[1]  = shadow_image[ly * DEF_MAX_WIDTH + hx];
      nb[2]  = shadow_image[hy * DEF_MAX_WIDTH + lx];
      nb[3]  = shadow_image[hy * DEF_MAX_WIDTH + hx];
      wgt[0] = lxw * lyw;
      wgt[1] = hxw * lyw;
      wgt[2] = lxw * hyw;
      wgt[3] = hxw * hyw;
      tot = xs + ys;
      // per channel quotient and remainder of the weighted sum
      for (int c = 0; c < 4; c++) begin
        sum = 0;
        for (int n = 0; n < 4; n++) sum += int'(nb[n][8*c +: 8]) * wgt[n];
        quo[c] = 8'(sum >> tot);
        rem[c] = 8'(sum & ((1 << tot) - 1));
      end
      res.red        = quo[0];
      res.green      = quo[1];
      res.blue       = quo[2];
      res.alpha      = quo[3];
      res.frac_red   = rem[0];
      res.frac_green = rem[1];
      res.frac_blue  = rem[2];
      res.frac_alpha = rem[3];
      return res;
    endfunction

    // accepted item: store the pixel or queue the expected result
    function void note_item(pixel_item_t it);
      pixel_result_t res;
      int            addr;
      if (it.opcode == OP_WRITE) begin
        writes_taken++;
        if (int'(it.coord_x) < eff_width() && int'(it.coord_y) < eff_height()) begin
          addr = int'(it.coord_y) * DEF_MAX_WIDTH + int'(it.coord_x);
          shadow_image[addr] = {it.alpha, it.blue, it.green, it.red};
          loaded[addr] = 1'b1;
        end
      end else begin
        queries_taken++;
        res = interpolate_pixel(it.coord_x, it.coord_y);
        if (res.range_error) outside_queries++;
        expected_pixels.push_back(res);
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at result %0d: %s", results_checked, msg);
    endtask

    task compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) report($sformatf("%s expected %0d got %0d", name, want, got));
    endtask

    // result strobe: compare with the oldest outstanding query
    task check_result(pixel_result_t got);
      pixel_result_t want;
      results_checked++;
      if (expected_pixels.size() == 0) begin
        report("result with no query outstanding");
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("out_red", want.red, got.red);
      compare_field("out_green", want.green, got.green);
      compare_field("out_blue", want.blue, got.blue);
      compare_field("out_alpha", want.alpha, got.alpha);
      compare_field("out_frac_red", want.frac_red, got.frac_red);
      compare_field("out_frac_green", want.frac_green, got.frac_green);
      compare_field("out_frac_blue", want.frac_blue, got.frac_blue);
      compare_field("out_frac_alpha", want.frac_alpha, got.frac_alpha);
      compare_field("out_range_error", 8'(want.range_error), 8'(got.range_error));
    endtask
  endclass

endpackage

module tb;
  import bup_pkg::*;
  import tb_upscale_pkg::*;

  localparam int SETTLE_CYCLES      = 10;
  localparam int RANDOM_PER_SETTING = 70;
  localparam int CYCLE_LIMIT        = 600000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_opcode = OP_WRITE;
  logic [9:0] in_coord_x = '0;
  logic [9:0] in_coord_y = '0;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic [7:0] in_alpha = '0;
  logic       out_valid;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic [7:0] out_frac_red;
  logic [7:0] out_frac_green;
  logic [7:0] out_frac_blue;
  logic [7:0] out_frac_alpha;
  logic       out_range_error;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  upscale_scoreboard sb;
  int unsigned       cycle_count = 0;
  int unsigned       settings_run = 0;
  bit                idle_enable = 1'b1;

  bilinear_upscale_pow2 u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .out_valid       (out_valid),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_frac_red    (out_frac_red),
    .out_frac_green  (out_frac_green),
    .out_frac_blue   (out_frac_blue),
    .out_frac_alpha  (out_frac_alpha),
    .out_range_error (out_range_error),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result monitor, samples the values present before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result('{out_red, out_green, out_blue, out_alpha, out_frac_red,
                        out_frac_green, out_frac_blue, out_frac_alpha, out_range_error});
    end
  end

  // channel value leaning towards the extremes
  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_item_t make_item(logic op, int x, int y);
    pixel_item_t it;
    it.opcode  = op;
    it.coord_x = 10'(x);
    it.coord_y = 10'(y);
    it.red     = rand_channel();
    it.green   = rand_channel();
    it.blue    = rand_channel();
    it.alpha   = rand_channel();
    return it;
  endfunction

  // random gap on the item side
  task automatic idle_gap();
    if (idle_enable && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // present one item and hold it until taken
  task automatic send_item(pixel_item_t it);
    idle_gap();
    start      <= 1'b1;
    in_opcode  <= it.opcode;
    in_coord_x <= it.coord_x;
    in_coord_y <= it.coord_y;
    in_red     <= it.red;
    in_green   <= it.green;
    in_blue    <= it.blue;
    in_alpha   <= it.alpha;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(it);
  endtask

  // stop sending until every query has answered, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [6:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(index, value);
  endtask

  task automatic configure(logic [6:0] w, logic [6:0] h, logic [2:0] xs, logic [2:0] ys,
                           logic wrap);
    drain();
    write_reg(CFG_SRC_WIDTH, w);
    write_reg(CFG_SRC_HEIGHT, h);
    write_reg(CFG_X_SHIFT, {4'b0, xs});
    write_reg(CFG_Y_SHIFT, {4'b0, ys});
    write_reg(CFG_EDGE_MODE, {6'b0, wrap});
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // write every pixel of the current image not yet written
  task automatic load_image();
    for (int y = 0; y < sb.eff_height(); y++) begin
      for (int x = 0; x < sb.eff_width(); x++) begin
        if (!sb.loaded[y * DEF_MAX_WIDTH + x]) send_item(make_item(OP_WRITE, x, y));
      end
    end
  endtask

  // corners of the enlarged image, just past them, and writes just outside
  task automatic probe_borders();
    int lim_x;
    int lim_y;
    lim_x = sb.eff_width() << sb.eff_xshift();
    lim_y = sb.eff_height() << sb.eff_yshift();
    send_item(make_item(OP_WRITE, sb.eff_width(), 0));
    send_item(make_item(OP_WRITE, 0, sb.eff_height()));
    send_item(make_item(OP_QUERY, 0, 0));
    send_item(make_item(OP_QUERY, lim_x - 1, 0));
    send_item(make_item(OP_QUERY, 0, lim_y - 1));
    send_item(make_item(OP_QUERY, lim_x - 1, lim_y - 1));
    send_item(make_item(OP_QUERY, lim_x, 0));
    send_item(make_item(OP_QUERY, 0, lim_y));
  endtask

  // mostly in-range queries, some in-range writes, a share of stray coordinates
  task automatic random_items(int count);
    int lim_x;
    int lim_y;
    pixel_item_t it;
    for (int i = 0; i < count; i++) begin
      lim_x = sb.eff_width() << sb.eff_xshift();
      lim_y = sb.eff_height() << sb.eff_yshift();
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 9) == 0)
          it = make_item(OP_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          it = make_item(OP_QUERY, $urandom_range(0, lim_x - 1), $urandom_range(0, lim_y - 1));
      end else begin
        if ($urandom_range(0, 4) == 0)
          it = make_item(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          it = make_item(OP_WRITE, $urandom_range(0, sb.eff_width() - 1),
                         $urandom_range(0, sb.eff_height() - 1));
      end
      send_item(it);
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  task automatic run_setting(logic [6:0] w, logic [6:0] h, logic [2:0] xs, logic [2:0] ys,
                             logic wrap, bit with_probe);
    configure(w, h, xs, ys, wrap);
    load_image();
    if (with_probe) probe_borders();
    random_items(RANDOM_PER_SETTING);
  endtask

  // stimulus
  initial begin
    logic [6:0] rand_w;
    logic [6:0] rand_h;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: nothing loaded, so only items that read no pixel
    send_item(make_item(OP_QUERY, 1023, 1023));
    send_item(make_item(OP_WRITE, 64, 0));
    send_item(make_item(OP_WRITE, 1023, 1023));

    // fixed settings: small odd image, zero width with the biggest shifts,
    // zero shift, oversized width and shifts in wrap mode on a thin strip,
    // a single column with oversized height
    run_setting(7'd4, 7'd3, 3'd1, 3'd2, 1'b0, 1'b1);
    run_setting(7'd0, 7'd1, 3'd4, 3'd4, 1'b1, 1'b1);
    run_setting(7'd5, 7'd7, 3'd0, 3'd0, 1'b0, 1'b1);
    run_setting(7'd127, 7'd2, 3'd7, 3'd5, 1'b1, 1'b0);
    run_setting(7'd1, 7'd127, 3'd2, 3'd0, 1'b1, 1'b0);

    // random settings, mostly small images; a large axis keeps the other narrow
    for (int p = 0; p < 4; p++) begin
      if (p == 3) idle_enable = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        rand_w = 7'($urandom_range(0, 127));
        rand_h = 7'($urandom_range(0, 2));
      end else if ($urandom_range(0, 2) == 0) begin
        rand_w = 7'($urandom_range(0, 2));
        rand_h = 7'($urandom_range(0, 127));
      end else begin
        rand_w = 7'($urandom_range(1, 10));
        rand_h = 7'($urandom_range(1, 10));
      end
      run_setting(rand_w, rand_h, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)), 1'b0);
    end

    drain();
    $display("covered %0d pixel writes and %0d queries (%0d outside the enlarged image)",
             sb.writes_taken, sb.queries_taken, sb.outside_queries);
    $display("over %0d register settings; %0d results checked, %0d mismatches",
             settings_run, sb.results_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
